// ----- sv/bdu_pkg.sv -----
// Shared types, constants and the plane gather/fold function.
`timescale 1ns / 1ps
package bdu_pkg;

    localparam int MAX_ROW_BYTES_DEF = 16384;
    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int ROW_W             = 13;
    localparam int BPP_W             = 3;
    localparam int QUEUE_DEPTH       = 2;
    localparam int HIST_DEPTH        = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd2;

    localparam logic [CFG_W-1:0] ROW_PIXELS_RST      = 13'd1;
    localparam logic [BPP_W-1:0] BYTES_PER_PIXEL_RST = 3'd4;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST       = 13'd1;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic            start;
    } t_group;

    typedef struct packed {
        logic [CFG_W-1:0] row_pixels;
        logic [BPP_W-1:0] bytes_per_pixel;
        logic [CFG_W-1:0] row_count;
    } t_cfg;

    function automatic logic [3:0][7:0] gather_fold(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c,
        input logic [7:0] d
    );
        logic [3:0][7:0] res;
        logic [7:0]      v;
        for (int j = 0; j < 4; j++) begin
            v      = {a[2*j +: 2], b[2*j +: 2], c[2*j +: 2], d[2*j +: 2]};
            res[j] = {1'b0, v[7:1]} ^ {8{v[0]}};
        end
        return res;
    endfunction

endpackage

// ----- sv/bdu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bdu_front.sv -----
// Front end: merge bit pairs of the four planes and sign-fold decode four bytes.
`timescale 1ns / 1ps
module bdu_front
    import bdu_pkg::*;
(
    input  logic       i_in_valid,
    input  logic [7:0] i_plane_a_byte,
    input  logic [7:0] i_plane_b_byte,
    input  logic [7:0] i_plane_c_byte,
    input  logic [7:0] i_plane_d_byte,
    input  logic       i_image_start,
    input  logic       i_q_ready,
    output logic       o_in_ready,
    output logic       o_push,
    output t_group     o_group
);

    assign o_group.bytes = gather_fold(i_plane_a_byte, i_plane_b_byte,
                                       i_plane_c_byte, i_plane_d_byte);
    assign o_group.start = i_image_start;
    assign o_in_ready    = i_q_ready;
    assign o_push        = i_in_valid & i_q_ready;

endmodule

// ----- sv/bdu_queue.sv -----
// Small register queue of decoded byte groups between front and back end.
`timescale 1ns / 1ps
module bdu_queue
    import bdu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    input  logic   i_pop,
    output logic   o_ready,
    output logic   o_valid,
    output t_group o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

// ----- sv/bdu_back.sv -----
// Back end: raster position tracking, line store, delta reconstruction, output register.
`timescale 1ns / 1ps
module bdu_back
    import bdu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_group     i_q_data,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pixel_byte,
    output logic       o_group_last
);

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int PROD_W = (CNT_W > CFG_W + BPP_W) ? CNT_W : CFG_W + BPP_W;
    localparam int HIDX_W = $clog2(HIST_DEPTH);

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_HORZ = 2'd1;
    localparam logic [1:0] MODE_VERT = 2'd2;

    function automatic logic [ROW_W-1:0] row_step(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] lim
    );
        return (r < lim) ? r + 1'b1 : r;
    endfunction

    logic [1:0]        r_sel;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic              r_s1_vld;
    logic [7:0]        r_s1_byte;
    logic [COL_W-1:0]  r_s1_col;
    logic [1:0]        r_s1_mode;
    logic              r_s1_wr;
    logic              r_s1_last;
    logic [HIDX_W-1:0] r_s1_dist;
    logic              r_s1_fwd;
    logic [7:0]        r_fwd_data;
    logic [7:0]        r_hist [HIST_DEPTH];

    logic              r_out_vld;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  stride;
    logic [ROW_W-1:0]  lim;
    logic              zero_stride;
    logic              start;
    logic [COL_W-1:0]  c0, c1;
    logic [ROW_W-1:0]  r0, r1;
    logic              pre_wrap, post_wrap;
    logic [CNT_W-1:0]  c2;
    logic [1:0]        mode;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic              out_free, move, enter;
    logic [7:0]        ram_rdata, above, addend, result;

    assign prod   = PROD_W'(i_cfg.row_pixels) * PROD_W'(i_cfg.bytes_per_pixel);
    assign stride = (prod > PROD_W'(MAX_ROW_BYTES)) ? CNT_W'(MAX_ROW_BYTES)
                                                    : prod[CNT_W-1:0];
    assign zero_stride = (stride == '0);
    assign lim   = (i_cfg.row_count == '0) ? ROW_W'(1) : i_cfg.row_count;
    assign start = i_q_data.start & (r_sel == 2'd0);

    always_comb begin
        c0        = start ? '0 : r_col;
        r0        = start ? '0 : r_row;
        pre_wrap  = (CNT_W'(c0) >= stride);
        c1        = pre_wrap ? '0 : c0;
        r1        = pre_wrap ? row_step(r0, lim) : r0;
        mode      = MODE_PASS;
        if (r1 == '0) begin
            if (CNT_W'(c1) >= CNT_W'(i_cfg.bytes_per_pixel)) begin
                mode = MODE_HORZ;
            end
        end else if (r1 < i_cfg.row_count) begin
            mode = MODE_VERT;
        end
        c2        = CNT_W'(c1) + CNT_W'(1);
        post_wrap = (c2 >= stride);
        n_col     = post_wrap ? '0 : c2[COL_W-1:0];
        n_row     = post_wrap ? row_step(r1, lim) : r1;
        if (zero_stride) begin
            mode  = MODE_PASS;
            n_col = c0;
            n_row = r0;
        end
    end

    assign out_free = !r_out_vld || i_out_ready;
    assign move     = r_s1_vld && out_free;
    assign enter    = i_q_valid && (!r_s1_vld || move);
    assign o_q_pop  = enter && (r_sel == 2'd3);

    assign above = r_s1_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        case (r_s1_mode)
            MODE_HORZ: addend = r_hist[r_s1_dist];
            MODE_VERT: addend = above;
            default:   addend = 8'd0;
        endcase
    end

    assign result = r_s1_byte + addend;

    bdu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (move && r_s1_wr),
        .i_waddr (r_s1_col),
        .i_wdata (result),
        .i_re    (enter),
        .i_raddr (c1),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (enter) begin
                r_sel <= r_sel + 1'b1;
                r_col <= n_col;
                r_row <= n_row;
            end
            if (enter) begin
                r_s1_vld <= 1'b1;
            end else if (move) begin
                r_s1_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enter) begin
            r_s1_byte  <= i_q_data.bytes[r_sel];
            r_s1_col   <= c1;
            r_s1_mode  <= mode;
            r_s1_wr    <= !zero_stride;
            r_s1_last  <= (r_sel == 2'd3);
            r_s1_dist  <= HIDX_W'(i_cfg.bytes_per_pixel - 1'b1);
            r_s1_fwd   <= move && r_s1_wr && (r_s1_col == c1);
            r_fwd_data <= result;
        end
        if (move && r_s1_wr) begin
            r_hist[0] <= result;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
        if (move) begin
            r_out_byte <= result;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_pixel_byte = r_out_byte;
    assign o_group_last = r_out_last;

endmodule

// ----- sv/bitplane_delta_image_unfilter_unit.sv -----
// Top level of the bit-plane merge and delta image reconstruction unit.
//
// Input channel (i_in_valid / o_in_ready): one transaction carries byte k of
// four planes and an image start flag. Output channel (o_out_valid /
// i_out_ready): four transactions per input, each one reconstructed image
// byte in raster order; group_last marks the fourth.
// The configuration port writes row_pixels, bytes_per_pixel and row_count
// through i_cfg_we / i_cfg_idx / i_cfg_data; write it only while idle.
// The first byte of an input passes through the queue, the stage-1 register
// and the output register; the others follow one per cycle unless the
// receiver stalls. The back end, one byte per cycle while not stalled, reads
// and writes the line store once per byte; the queue can take the next input meanwhile.
// Reset clears the raster position, queue and output valid and loads the
// register defaults; the line store is left uninitialized and its read data
// is used only at entries already written.
// When the receiver stalls, the output register holds its byte, the back end
// halts and the two-entry queue fills before o_in_ready drops.
`timescale 1ns / 1ps
module bitplane_delta_image_unfilter_unit
    import bdu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_plane_a_byte,
    input  logic [7:0]           i_plane_b_byte,
    input  logic [7:0]           i_plane_c_byte,
    input  logic [7:0]           i_plane_d_byte,
    input  logic                 i_image_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_pixel_byte,
    output logic                 o_group_last
);

    t_cfg   r_cfg;
    t_group front_group, q_group;
    logic   push, q_ready, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_pixels      <= ROW_PIXELS_RST;
            r_cfg.bytes_per_pixel <= BYTES_PER_PIXEL_RST;
            r_cfg.row_count       <= ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_PIXELS:      r_cfg.row_pixels      <= i_cfg_data;
                CFG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_COUNT:       r_cfg.row_count       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bdu_front u_front (
        .i_in_valid     (i_in_valid),
        .i_plane_a_byte (i_plane_a_byte),
        .i_plane_b_byte (i_plane_b_byte),
        .i_plane_c_byte (i_plane_c_byte),
        .i_plane_d_byte (i_plane_d_byte),
        .i_image_start  (i_image_start),
        .i_q_ready      (q_ready),
        .o_in_ready     (o_in_ready),
        .o_push         (push),
        .o_group        (front_group)
    );

    bdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_group),
        .i_pop   (q_pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_group)
    );

    bdu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_data     (q_group),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_byte (o_pixel_byte),
        .o_group_last (o_group_last)
    );

endmodule
